@@ design/ktrc_pkg.sv @@
`default_nettype none
package ktrc_pkg;

   // key codes
   localparam logic [4:0] KEY_FWD   = 5'd1;
   localparam logic [4:0] KEY_BACK  = 5'd2;
   localparam logic [4:0] KEY_LEFT  = 5'd3;
   localparam logic [4:0] KEY_RIGHT = 5'd4;
   localparam logic [4:0] KEY_Q     = 5'd5;
   localparam logic [4:0] KEY_E     = 5'd6;
   localparam logic [4:0] KEY_Z     = 5'd7;
   localparam logic [4:0] KEY_R     = 5'd8;
   localparam logic [4:0] KEY_SPACE = 5'd9;
   localparam logic [4:0] KEY_DIG1  = 5'd10;
   localparam logic [4:0] KEY_DIG7  = 5'd16;

   // held commands
   localparam logic [3:0] CMD_NONE   = 4'd0;
   localparam logic [3:0] CMD_ESTOP  = 4'd8;
   localparam logic [3:0] CMD_ACTIVE = 4'd9;

   // movement flag bits
   localparam logic [5:0] FLAG_FWD   = 6'b000001;
   localparam logic [5:0] FLAG_BACK  = 6'b000010;
   localparam logic [5:0] FLAG_LEFT  = 6'b000100;
   localparam logic [5:0] FLAG_RIGHT = 6'b001000;
   localparam logic [5:0] FLAG_Q     = 6'b010000;
   localparam logic [5:0] FLAG_E     = 6'b100000;
   localparam logic [5:0] FLAGS_DIR4 = 6'b001111;
   localparam logic [5:0] FLAGS_ALL6 = 6'b111111;

   localparam logic [3:0] AXES_JOY   = 4'b1111;
   localparam logic [3:0] AXES_TWIST = 4'b0111;

   // configuration register indexes
   localparam logic [2:0] CSR_TWIST_MODE   = 3'd0;
   localparam logic [2:0] CSR_MAX_LINEAR   = 3'd1;
   localparam logic [2:0] CSR_MAX_ANGULAR  = 3'd2;
   localparam logic [2:0] CSR_STEP_LINEAR  = 3'd3;
   localparam logic [2:0] CSR_STEP_ANGULAR = 3'd4;

   localparam logic [14:0] MAX_RESET  = 15'd4096;
   localparam logic [14:0] STEP_RESET = 15'd205;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        twist_mode;
      logic [14:0] max_linear;
      logic [14:0] max_angular;
      logic [14:0] step_linear;
      logic [14:0] step_angular;
   } cfg_type;

   // decoded item
   typedef struct packed {
      logic       tick;
      logic       flag_we;
      logic [5:0] flag_mask;
      logic       down;
      logic       cmd_en;
      logic [3:0] cmd_code;
      logic       stop;
      logic [5:0] clr_mask;
      logic [3:0] zero_mask;
   } op_type;

endpackage
`default_nettype wire

@@ design/key_throttle_ramp_controller.sv @@
// A send tick accepted into the queue passes on into the output register, and its result then shows on rsp_*.
// Throughput: one item per cycle. While a result waits under rsp_stall, key events keep
// draining; a send tick at the queue head waits, and the two-entry queue then fills.
// Key events give no result and are absorbed by the back end one per cycle.
// Reset (synchronous, active high) clears flags, axes, latch, queue and output valid,
// and loads the default configuration.
`default_nettype none
module key_throttle_ramp_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic [4:0]         req_key_code,
   input  wire logic               req_key_down,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_axis_0,
   output logic signed [15:0]      rsp_axis_1,
   output logic signed [15:0]      rsp_axis_2,
   output logic signed [15:0]      rsp_axis_3,
   output logic [3:0]              rsp_held_command,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [14:0]        csr_data
);

   ktrc_pkg::cfg_type cfg_ff, cfg_in;
   ktrc_pkg::op_type  q_data;
   ktrc_pkg::op_type  head;
   logic              q_push;
   logic              q_full;
   logic              head_valid;
   logic              pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ktrc_pkg::CSR_TWIST_MODE:   cfg_in.twist_mode   = csr_data[0];
            ktrc_pkg::CSR_MAX_LINEAR:   cfg_in.max_linear   = csr_data;
            ktrc_pkg::CSR_MAX_ANGULAR:  cfg_in.max_angular  = csr_data;
            ktrc_pkg::CSR_STEP_LINEAR:  cfg_in.step_linear  = csr_data;
            ktrc_pkg::CSR_STEP_ANGULAR: cfg_in.step_angular = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.twist_mode   <= 1'b0;
         cfg_ff.max_linear   <= ktrc_pkg::MAX_RESET;
         cfg_ff.max_angular  <= ktrc_pkg::MAX_RESET;
         cfg_ff.step_linear  <= ktrc_pkg::STEP_RESET;
         cfg_ff.step_angular <= ktrc_pkg::STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ktrc_front u_front (
      .twist_mode   (cfg_ff.twist_mode),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_key_code (req_key_code),
      .req_key_down (req_key_down),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_data)
   );

   ktrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   ktrc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_axis_0       (rsp_axis_0),
      .rsp_axis_1       (rsp_axis_1),
      .rsp_axis_2       (rsp_axis_2),
      .rsp_axis_3       (rsp_axis_3),
      .rsp_held_command (rsp_held_command)
   );

endmodule
`default_nettype wire

@@ design/ktrc_front.sv @@
`default_nettype none
module ktrc_front (
   input  wire logic              twist_mode,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_kind,
   input  wire logic [4:0]        req_key_code,
   input  wire logic              req_key_down,
   input  wire logic              q_full,
   output logic                   q_push,
   output ktrc_pkg::op_type       q_data
);

   logic [5:0] clr;
   logic [3:0] zero;
   logic [4:0] dig;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign clr       = twist_mode ? ktrc_pkg::FLAGS_ALL6 : ktrc_pkg::FLAGS_DIR4;
   assign zero      = twist_mode ? ktrc_pkg::AXES_TWIST : ktrc_pkg::AXES_JOY;
   assign dig       = req_key_code - ktrc_pkg::KEY_DIG1 + 5'd1;

   always_comb begin
      q_data           = '0;
      q_data.down      = req_key_down;
      q_data.clr_mask  = clr;
      q_data.zero_mask = zero;
      if (req_kind) begin
         q_data.tick = 1'b1;
      end else begin
         case (req_key_code)
            ktrc_pkg::KEY_FWD: begin
               q_data.flag_we   = 1'b1;
               q_data.flag_mask = ktrc_pkg::FLAG_FWD;
            end
            ktrc_pkg::KEY_BACK: begin
               q_data.flag_we   = 1'b1;
               q_data.flag_mask = ktrc_pkg::FLAG_BACK;
            end
            ktrc_pkg::KEY_LEFT: begin
               q_data.flag_we   = 1'b1;
               q_data.flag_mask = ktrc_pkg::FLAG_LEFT;
            end
            ktrc_pkg::KEY_RIGHT: begin
               q_data.flag_we   = 1'b1;
               q_data.flag_mask = ktrc_pkg::FLAG_RIGHT;
            end
            ktrc_pkg::KEY_Q: begin
               if (twist_mode) begin
                  q_data.flag_we   = 1'b1;
                  q_data.flag_mask = ktrc_pkg::FLAG_Q;
               end
            end
            ktrc_pkg::KEY_E: begin
               if (twist_mode) begin
                  q_data.flag_we   = 1'b1;
                  q_data.flag_mask = ktrc_pkg::FLAG_E;
               end else begin
                  q_data.cmd_en   = 1'b1;
                  q_data.cmd_code = ktrc_pkg::CMD_ESTOP;
               end
            end
            ktrc_pkg::KEY_Z: begin
               if (twist_mode) begin
                  q_data.cmd_en   = 1'b1;
                  q_data.cmd_code = ktrc_pkg::CMD_ESTOP;
               end
            end
            ktrc_pkg::KEY_R: begin
               q_data.cmd_en   = 1'b1;
               q_data.cmd_code = ktrc_pkg::CMD_ACTIVE;
            end
            ktrc_pkg::KEY_SPACE: begin
               q_data.stop = req_key_down;
            end
            default: begin
               // digit buttons, joystick mode only
               if (!twist_mode && req_key_code >= ktrc_pkg::KEY_DIG1
                   && req_key_code <= ktrc_pkg::KEY_DIG7) begin
                  q_data.cmd_en   = 1'b1;
                  q_data.cmd_code = dig[3:0];
               end
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ design/ktrc_queue.sv @@
`default_nettype none
module ktrc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ktrc_pkg::op_type  push_data,
   output logic                   full,
   output logic                   head_valid,
   output ktrc_pkg::op_type       head,
   input  wire logic              pop
);

   localparam int PTR_W = $clog2(ktrc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ktrc_pkg::QUEUE_DEPTH + 1);

   ktrc_pkg::op_type entry_ff [ktrc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(ktrc_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ktrc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ktrc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ design/ktrc_back.sv @@
`default_nettype none
module ktrc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ktrc_pkg::cfg_type  cfg,
   input  wire logic               head_valid,
   input  wire ktrc_pkg::op_type   head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_axis_0,
   output logic signed [15:0]      rsp_axis_1,
   output logic signed [15:0]      rsp_axis_2,
   output logic signed [15:0]      rsp_axis_3,
   output logic [3:0]              rsp_held_command
);

   function automatic logic signed [17:0] ramp(input logic signed [17:0] cur,
                                               input logic signed [17:0] tgt,
                                               input logic signed [17:0] step);
      logic signed [17:0] up;
      logic signed [17:0] dn;
      logic signed [17:0] r;
      up = cur + step;
      dn = cur - step;
      r  = cur;
      if (cur < tgt) begin
         r = (up > tgt) ? tgt : up;
      end else if (cur > tgt) begin
         r = (dn < tgt) ? tgt : dn;
      end
      return r;
   endfunction

   logic [5:0]         flags_ff, flags_in;
   logic [3:0]         latch_ff, latch_in;
   logic signed [15:0] axis_ff [4];
   logic signed [15:0] axis_in [4];
   logic               out_valid_ff, out_valid_in;
   logic signed [15:0] out_axis_ff [4];
   logic [3:0]         out_cmd_ff;

   logic               out_free;
   logic               do_tick;
   logic signed [17:0] lin, ang, step_l, step_a;
   logic signed [17:0] fwd_t, back_t, left_t, right_t, q_t, e_t;
   logic signed [17:0] tgt [4];
   logic signed [17:0] stp [4];
   logic signed [17:0] nxt [4];

   assign out_free = !out_valid_ff || !rsp_stall;
   assign pop      = head_valid && (!head.tick || out_free);
   assign do_tick  = pop && head.tick;

   assign lin     = {3'b000, cfg.max_linear};
   assign ang     = {3'b000, cfg.max_angular};
   assign step_l  = {3'b000, cfg.step_linear};
   assign step_a  = {3'b000, cfg.step_angular};
   assign fwd_t   = flags_ff[0] ? lin : '0;
   assign back_t  = flags_ff[1] ? lin : '0;
   assign left_t  = flags_ff[2] ? ang : '0;
   assign right_t = flags_ff[3] ? ang : '0;
   assign q_t     = flags_ff[4] ? lin : '0;
   assign e_t     = flags_ff[5] ? lin : '0;

   always_comb begin
      if (cfg.twist_mode) begin
         tgt[0] = fwd_t - back_t;
         tgt[1] = q_t - e_t;
         tgt[2] = left_t - right_t;
         tgt[3] = {{2{axis_ff[3][15]}}, axis_ff[3]};
      end else begin
         tgt[0] = fwd_t;
         tgt[1] = back_t;
         tgt[2] = left_t;
         tgt[3] = right_t;
      end
      stp[0] = step_l;
      stp[1] = step_l;
      stp[2] = step_a;
      stp[3] = step_a;
      for (int i = 0; i < 4; i++) begin
         nxt[i] = ramp({{2{axis_ff[i][15]}}, axis_ff[i]}, tgt[i], stp[i]);
      end
   end

   always_comb begin
      flags_in = flags_ff;
      latch_in = latch_ff;
      for (int i = 0; i < 4; i++) begin
         axis_in[i] = axis_ff[i];
      end
      if (do_tick) begin
         for (int i = 0; i < 4; i++) begin
            axis_in[i] = nxt[i][15:0];
         end
      end else if (pop) begin
         if (head.flag_we) begin
            flags_in = head.down ? (flags_ff | head.flag_mask)
                                 : (flags_ff & ~head.flag_mask);
         end
         if (head.cmd_en) begin
            if (head.down) begin
               if (latch_ff != head.cmd_code) begin
                  latch_in = head.cmd_code;
                  if (head.cmd_code == ktrc_pkg::CMD_ESTOP) begin
                     flags_in = flags_ff & ~head.clr_mask;
                     for (int i = 0; i < 4; i++) begin
                        if (head.zero_mask[i]) axis_in[i] = '0;
                     end
                  end
               end
            end else if (latch_ff == head.cmd_code) begin
               latch_in = ktrc_pkg::CMD_NONE;
            end
         end
         if (head.stop) begin
            flags_in = flags_ff & ~head.clr_mask;
            latch_in = ktrc_pkg::CMD_NONE;
            for (int i = 0; i < 4; i++) begin
               if (head.zero_mask[i]) axis_in[i] = '0;
            end
         end
      end
   end

   always_comb begin
      if (do_tick) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         latch_ff     <= ktrc_pkg::CMD_NONE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            axis_ff[i] <= '0;
         end
      end else begin
         flags_ff     <= flags_in;
         latch_ff     <= latch_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < 4; i++) begin
            axis_ff[i] <= axis_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_tick) begin
         out_axis_ff[0] <= nxt[0][15:0];
         out_axis_ff[1] <= nxt[1][15:0];
         out_axis_ff[2] <= nxt[2][15:0];
         out_axis_ff[3] <= cfg.twist_mode ? 16'sd0 : nxt[3][15:0];
         out_cmd_ff     <= latch_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_axis_0       = out_axis_ff[0];
   assign rsp_axis_1       = out_axis_ff[1];
   assign rsp_axis_2       = out_axis_ff[2];
   assign rsp_axis_3       = out_axis_ff[3];
   assign rsp_held_command = out_cmd_ff;

endmodule
`default_nettype wire

@@ design/ktrc_checker.sv @@
`default_nettype none
module ktrc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               req_kind,
   input wire logic [4:0]         req_key_code,
   input wire logic               req_key_down,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_axis_0,
   input wire logic signed [15:0] rsp_axis_1,
   input wire logic signed [15:0] rsp_axis_2,
   input wire logic signed [15:0] rsp_axis_3,
   input wire logic [3:0]         rsp_held_command,
   input wire logic               csr_valid,
   input wire logic               csr_ready,
   input wire logic [2:0]         csr_index,
   input wire logic [14:0]        csr_data
);

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_axis_0)
         && $stable(rsp_axis_1) && $stable(rsp_axis_2) && $stable(rsp_axis_3)
         && $stable(rsp_held_command))
      else $error("result changed while stalled");

   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_held_command <= 4'd9)
      else $error("held command out of range");

   // ramp never overshoots a target within +/-32767
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_axis_0 != 16'sh8000 && rsp_axis_1 != 16'sh8000
         && rsp_axis_2 != 16'sh8000 && rsp_axis_3 != 16'sh8000)
      else $error("axis value out of range");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind key_throttle_ramp_controller ktrc_checker u_ktrc_checker (.*);
`default_nettype wire
